@@ rtl/mjcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mjcw_pkg: shared types for the minimum jump cost window block
// Field widths, item structures and the sequencer state type.
// ----------------------------------------------------------------------------
package mjcw_pkg;

    localparam int HEIGHT_BITS = 16;
    localparam int COST_BITS   = 48;
    localparam int LIMIT_BITS  = 5;

    typedef struct packed {
        logic [HEIGHT_BITS-1:0] height;
        logic                   new_sequence;
    } t_in_item;

    typedef struct packed {
        logic [COST_BITS-1:0] best_cost;
        logic                 saturated;
    } t_out_item;

    // One window entry as it sits in the memory.
    typedef struct packed {
        logic [HEIGHT_BITS-1:0] height;
        logic [COST_BITS-1:0]   cost;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

@@ rtl/min_jump_cost_window_dp_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// min_jump_cost_window_dp_top: windowed minimum jump cost engine
// Computes, for every stone height, the least saturating cost to reach it.
// ----------------------------------------------------------------------------
// Each accepted item is one stone. The block returns one result item per
// stone: the minimum over the most recent min(jump_limit, stones seen) stones
// of the current sequence of that stone's cost plus the absolute height
// difference, clipped at the largest 48-bit value. The first stone of a
// sequence, and any stone arriving with an empty window, costs zero. The
// window lives in one synchronous memory of MAX_JUMP entries used as a ring;
// a fill count marks how many entries are live, so no clearing pass is
// needed after reset. A stone is accepted, then its span, which is
// min(jump_limit, stones seen) and at most MAX_JUMP, is scanned with one
// registered memory read per window entry through a single abs-add-compare
// unit, and the new entry is written back. The default limit is two. The
// result waits in an output register; while it waits the next stone is
// accepted and scanned, and its write-back holds until the earlier result
// is taken. jump_limit is written on its own channel; the user must write
// it only while the block is idle, which the block itself does not enforce;
// zero is treated as one and values above MAX_JUMP as MAX_JUMP.
// ----------------------------------------------------------------------------
module min_jump_cost_window_dp_top #(
    parameter int MAX_JUMP = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [mjcw_pkg::LIMIT_BITS-1:0] i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  mjcw_pkg::t_in_item     i_in_data,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output mjcw_pkg::t_out_item          o_out_data
);
    import mjcw_pkg::*;

    // Count of live entries, able to hold MAX_JUMP itself.
    localparam int CNT_W = $clog2(MAX_JUMP + 1);
    // Ring pointer into the window memory.
    localparam int PTR_W = (MAX_JUMP > 1) ? $clog2(MAX_JUMP) : 1;
    // Width in which the limit and the fill count are compared.
    localparam int LIM_W = (CNT_W > LIMIT_BITS) ? CNT_W : LIMIT_BITS;
    // The candidate sum needs one bit above the wider of its operands.
    localparam int SUM_W = ((HEIGHT_BITS > COST_BITS) ? HEIGHT_BITS : COST_BITS) + 1;

    localparam logic [PTR_W-1:0]     LAST_PTR = PTR_W'(MAX_JUMP - 1);
    localparam logic [CNT_W-1:0]     FULL_CNT = CNT_W'(MAX_JUMP);
    localparam logic [LIM_W-1:0]     MAX_LIM  = LIM_W'(MAX_JUMP);
    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};
    localparam logic [SUM_W-1:0]     SUM_MAX  = SUM_W'(COST_MAX);

    // Window memory: one entry per stone, written at the ring head.
    t_entry r_mem [MAX_JUMP];
    t_entry r_rd_data;

    t_state r_state, n_state;

    logic [LIMIT_BITS-1:0]  r_jump_limit;
    logic [CNT_W-1:0]       r_fill;
    logic [PTR_W-1:0]       r_wp;
    logic [PTR_W-1:0]       r_rp;
    logic [CNT_W-1:0]       r_span;
    logic [CNT_W-1:0]       r_rd_cnt;
    logic                   r_rd_vld;
    logic [HEIGHT_BITS-1:0] r_h;
    logic [COST_BITS-1:0]   r_best;
    logic                   r_sat;
    logic                   r_out_valid;
    t_out_item              r_out_data;

    logic                   in_fire;
    logic                   done_fire;
    logic                   rd_issue;
    logic [CNT_W-1:0]       fill_eff;
    logic [LIM_W-1:0]       lim_raw;
    logic [LIM_W-1:0]       lim_eff;
    logic [LIM_W-1:0]       fill_ext;
    logic [CNT_W-1:0]       span_new;
    logic [HEIGHT_BITS-1:0] diff;
    logic [SUM_W-1:0]       sum;
    logic                   take;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Span of the window to scan for the stone being offered.
    always_comb begin
        fill_eff = i_in_data.new_sequence ? '0 : r_fill;
        lim_raw  = LIM_W'(r_jump_limit);
        if (lim_raw == '0) begin
            lim_eff = LIM_W'(1);
        end else if (lim_raw > MAX_LIM) begin
            lim_eff = MAX_LIM;
        end else begin
            lim_eff = lim_raw;
        end
        fill_ext = LIM_W'(fill_eff);
        span_new = (fill_ext < lim_eff) ? fill_eff : CNT_W'(lim_eff);
    end

    // Shared abs-add-compare unit on the entry just read.
    always_comb begin
        diff = (r_h >= r_rd_data.height) ? (r_h - r_rd_data.height)
                                         : (r_rd_data.height - r_h);
        sum  = SUM_W'(r_rd_data.cost) + SUM_W'(diff);
        // A candidate above the field maximum is dropped; an exact one
        // at the maximum still beats the clipped default.
        take = r_rd_vld && (sum <= SUM_MAX) &&
               (r_sat || (sum[COST_BITS-1:0] < r_best));
    end

    // Sequencer: next state and handshake.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        in_fire    = 1'b0;
        done_fire  = 1'b0;
        rd_issue   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                in_fire    = i_in_valid;
                if (i_in_valid) begin
                    n_state = (span_new == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                rd_issue = (r_rd_cnt != r_span);
                // The last read's data is compared in this cycle.
                if (r_rd_cnt == r_span) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                done_fire = !r_out_valid || i_out_ready;
                if (done_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window memory: write port at the ring head, registered read port.
    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_mem[r_wp] <= '{height: r_h, cost: r_best};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_limit <= LIMIT_BITS'(2);
            r_fill       <= '0;
            r_wp         <= '0;
            r_rd_cnt     <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_jump_limit <= i_cfg_data;
            end
            r_rd_vld <= rd_issue;
            if (in_fire) begin
                r_fill   <= fill_eff;
                r_rd_cnt <= '0;
            end else if (rd_issue) begin
                r_rd_cnt <= r_rd_cnt + CNT_W'(1);
            end
            if (done_fire) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + PTR_W'(1);
                if (r_fill != FULL_CNT) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_h    <= i_in_data.height;
            r_span <= span_new;
            // Newest entry sits just behind the write pointer.
            r_rp   <= (r_wp == '0) ? LAST_PTR : r_wp - PTR_W'(1);
            if (span_new == '0) begin
                r_best <= '0;
                r_sat  <= 1'b0;
            end else begin
                r_best <= COST_MAX;
                r_sat  <= 1'b1;
            end
        end else begin
            if (rd_issue) begin
                r_rp <= (r_rp == '0) ? LAST_PTR : r_rp - PTR_W'(1);
            end
            if (take) begin
                r_best <= sum[COST_BITS-1:0];
                r_sat  <= 1'b0;
            end
        end
        if (done_fire) begin
            r_out_data <= '{best_cost: r_best, saturated: r_sat};
        end
    end

    // The live entry count never exceeds the window depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("fill count above window depth");

    // Reads never run past the span of the stone being scanned.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd_cnt <= r_span))
        else $error("window scan ran past its span");

    // A fresh sequence empties the window for the stone that opens it.
    a_fresh_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.new_sequence) |=> (r_fill == '0))
        else $error("new sequence did not clear the window");

    // A saturated result always carries the clipped maximum.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_sat) |-> (r_best == COST_MAX))
        else $error("saturated result without maximum cost");

    // Finishing a stone always presents its result next cycle.
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_fire |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished stone did not present a result");

endmodule
`default_nettype wire
